FILE: sv/tdf_pkg.sv
package tdf_pkg;

    // Default width of the value being factored
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the beat fields
    localparam int IN_W    = 32;
    localparam int PRIME_W = 32;
    localparam int EXP_W   = 6;

    // Result limit per input value
    localparam int MAX_RESULTS   = 9;
    localparam int FIRST_DIVISOR = 2;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [EXP_W-1:0] exp_t;

    localparam cnt_t CNT_ONE = cnt_t'(1);
    localparam cnt_t CNT_MAX = cnt_t'(MAX_RESULTS);
    localparam exp_t EXP_ONE = exp_t'(1);

    // One result beat
    typedef struct packed {
        logic [PRIME_W-1:0] prime_factor;
        exp_t               exponent;
        logic               last;
        logic               no_factors;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_PUSH,
        S_FINISH,
        S_LASTOUT
    } state_t;

endpackage

FILE: sv/tdf_divider.sv
module tdf_divider #(
    parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  q_next;
    logic [W-1:0]  r_next;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb
    begin
        shifted = {r_reg, q_reg[W-1]};
        diff    = shifted - {1'b0, divisor};
        // partial remainder stays below twice the divisor, so bit W is the borrow
        ge      = ~diff[W];
        r_next  = ge ? diff[W-1:0] : shifted[W-1:0];
        q_next  = {q_reg[W-2:0], ge};
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient / partial remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: sv/tdf_sequencer.sv
module tdf_sequencer #(
    parameter int VB = tdf_pkg::VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [tdf_pkg::IN_W-1:0] value,
    input  logic                    out_free,
    output logic                    push_valid,
    output tdf_pkg::result_t        push_data,
    output logic                    div_start,
    input  logic                    div_done,
    input  logic [VB-1:0]           div_quot,
    input  logic [VB-1:0]           div_rem,
    output logic [VB-1:0]           dividend,
    output logic [VB-1:0]           divisor
);

    localparam int WIDE = (VB > tdf_pkg::PRIME_W) ? VB : tdf_pkg::PRIME_W;

    tdf_pkg::state_t  state_reg, state_next;
    logic [VB-1:0]    rem_reg, rem_next;
    logic [VB-1:0]    div_reg, div_next;
    tdf_pkg::exp_t    mult_reg, mult_next;
    tdf_pkg::cnt_t    cnt_reg, cnt_next;
    logic             inner_reg, inner_next;
    logic             pend_valid_reg, pend_valid_next;
    tdf_pkg::result_t pend_reg, pend_next;

    logic [VB-1:0]    val_in;
    logic             val_trivial;
    logic             rem_gt1;
    logic             can_move;
    logic [WIDE-1:0]  div_wide;
    logic [WIDE-1:0]  rem_wide;
    tdf_pkg::result_t cand;

    assign val_in      = VB'(value);
    assign val_trivial = (val_in[VB-1:1] == '0);
    assign rem_gt1     = (rem_reg[VB-1:1] != '0);
    assign div_wide    = WIDE'(div_reg);
    assign rem_wide    = WIDE'(rem_reg);
    // pending beat may move on only if the output stage takes it
    assign can_move    = ~pend_valid_reg | out_free;
    assign dividend    = rem_reg;
    assign divisor     = div_reg;

    // Candidate result: found divisor power, or the leftover prime
    always_comb
    begin
        cand            = '0;
        if (state_reg == tdf_pkg::S_FINISH)
        begin
            cand.prime_factor = rem_wide[tdf_pkg::PRIME_W-1:0];
            cand.exponent     = tdf_pkg::EXP_ONE;
        end
        else
        begin
            cand.prime_factor = div_wide[tdf_pkg::PRIME_W-1:0];
            cand.exponent     = mult_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdf_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = val_trivial ? tdf_pkg::S_LASTOUT : tdf_pkg::S_START;
            end
            tdf_pkg::S_START:
            begin
                state_next = tdf_pkg::S_WAIT;
            end
            tdf_pkg::S_WAIT:
            begin
                if (div_done)
                begin
                    if (!inner_reg)
                        state_next = (div_reg > div_quot) ? tdf_pkg::S_FINISH
                                                          : tdf_pkg::S_START;
                    else
                        state_next = (div_rem == '0) ? tdf_pkg::S_START
                                                     : tdf_pkg::S_PUSH;
                end
            end
            tdf_pkg::S_PUSH:
            begin
                if (can_move)
                    state_next = (cnt_reg + tdf_pkg::CNT_ONE == tdf_pkg::CNT_MAX)
                                 ? tdf_pkg::S_LASTOUT : tdf_pkg::S_START;
            end
            tdf_pkg::S_FINISH:
            begin
                if (!rem_gt1 || can_move)
                    state_next = tdf_pkg::S_LASTOUT;
            end
            tdf_pkg::S_LASTOUT:
            begin
                if (out_free)
                    state_next = tdf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tdf_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        in_ready        = 1'b0;
        div_start       = 1'b0;
        push_valid      = 1'b0;
        push_data       = pend_reg;
        push_data.last  = 1'b0;
        rem_next        = rem_reg;
        div_next        = div_reg;
        mult_next       = mult_reg;
        cnt_next        = cnt_reg;
        inner_next      = inner_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        unique case (state_reg)
            tdf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rem_next        = val_in;
                    div_next        = VB'(tdf_pkg::FIRST_DIVISOR);
                    mult_next       = '0;
                    cnt_next        = '0;
                    inner_next      = 1'b0;
                    pend_next       = '0;
                    pend_next.no_factors = val_trivial;
                    pend_valid_next = val_trivial;
                end
            end
            tdf_pkg::S_START:
            begin
                div_start = 1'b1;
            end
            tdf_pkg::S_WAIT:
            begin
                if (div_done)
                begin
                    if (!inner_reg)
                    begin
                        if (div_reg <= div_quot)
                        begin
                            if (div_rem == '0)
                            begin
                                rem_next   = div_quot;
                                mult_next  = tdf_pkg::EXP_ONE;
                                inner_next = 1'b1;
                            end
                            else
                            begin
                                div_next = div_reg + VB'(1);
                            end
                        end
                    end
                    else if (div_rem == '0)
                    begin
                        rem_next  = div_quot;
                        mult_next = mult_reg + tdf_pkg::EXP_ONE;
                    end
                    else
                    begin
                        inner_next = 1'b0;
                    end
                end
            end
            tdf_pkg::S_PUSH:
            begin
                if (can_move)
                begin
                    push_valid      = pend_valid_reg;
                    pend_next       = cand;
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + tdf_pkg::CNT_ONE;
                    div_next        = div_reg + VB'(1);
                end
            end
            tdf_pkg::S_FINISH:
            begin
                if (rem_gt1 && can_move)
                begin
                    push_valid      = pend_valid_reg;
                    pend_next       = cand;
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + tdf_pkg::CNT_ONE;
                end
            end
            tdf_pkg::S_LASTOUT:
            begin
                // final beat of this value carries last
                if (out_free)
                begin
                    push_valid      = 1'b1;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tdf_pkg::S_IDLE;
            inner_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            inner_reg      <= inner_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        mult_reg <= mult_next;
        pend_reg <= pend_next;
    end

endmodule

FILE: sv/trial_division_factorizer_unit.sv
// Trial-division prime factorizer, one value at a time.
// Each trial divisor costs one divide on the shared bit-serial divider,
// plus one more divide per power of a found prime and a push step; a 32-bit prime walks
// about 65536 trial divisors, and a value of 0 or 1 gives its single beat.
// in_ready is high only while the sequencer idles; results drain through one output register.
// rst_n is asynchronous, active low: sequencer idles, no pending or output beat.
module trial_division_factorizer_unit #(
    parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tdf_pkg::IN_W-1:0]    value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tdf_pkg::PRIME_W-1:0] prime_factor,
    output logic [tdf_pkg::EXP_W-1:0]   exponent,
    output logic                        last,
    output logic                        no_factors
);

    logic                   out_valid_reg;
    tdf_pkg::result_t       out_data_reg;
    logic                   out_free;
    logic                   push_valid;
    tdf_pkg::result_t       push_data;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_BITS-1:0]  div_quot;
    logic [VALUE_BITS-1:0]  div_rem;
    logic [VALUE_BITS-1:0]  dividend;
    logic [VALUE_BITS-1:0]  divisor;

    assign out_free = ~out_valid_reg | out_ready;

    tdf_sequencer #(
        .VB (VALUE_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_free   (out_free),
        .push_valid (push_valid),
        .push_data  (push_data),
        .div_start  (div_start),
        .div_done   (div_done),
        .div_quot   (div_quot),
        .div_rem    (div_rem),
        .dividend   (dividend),
        .divisor    (divisor)
    );

    tdf_divider #(
        .W (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            out_data_reg <= push_data;
    end

    assign out_valid    = out_valid_reg;
    assign prime_factor = out_data_reg.prime_factor;
    assign exponent     = out_data_reg.exponent;
    assign last         = out_data_reg.last;
    assign no_factors   = out_data_reg.no_factors;

endmodule

FILE: sv/tdf_checker.sv
module tdf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tdf_pkg::PRIME_W-1:0] prime_factor,
    input logic [tdf_pkg::EXP_W-1:0]   exponent,
    input logic                        last,
    input logic                        no_factors
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prime_factor)
                                    && $stable(exponent) && $stable(last))
        else $error("output beat changed while stalled");

    // Block goes busy right after taking a value
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready again right after accept");

    // The no-factor beat is a lone, empty, final beat
    a_no_factor_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_factors |-> last && prime_factor == '0 && exponent == '0)
        else $error("bad no-factor beat");

    // Every real factor is at least 2 with a nonzero exponent
    a_factor_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !no_factors |-> prime_factor > 1 && exponent != '0)
        else $error("bad factor beat");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (.*);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = tdf_pkg::VALUE_BITS_DEF;
    localparam logic [63:0] VALUE_MASK = (VB >= 64) ? '1 : ((64'd1 << VB) - 64'd1);
    localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;
    localparam int N_SMALL = 18;
    localparam int N_RANDOM = 80;

    // One directed row; last is always 1 on the typed single-beat rows
    typedef struct packed {
        logic [31:0]               v;
        logic                      typed;
        logic [31:0]               p;
        logic [tdf_pkg::EXP_W-1:0] e;
        logic                      nf;
    } dir_row_t;

    localparam int N_DIR = 21;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [tdf_pkg::IN_W-1:0]     value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [tdf_pkg::PRIME_W-1:0]  prime_factor;
    logic [tdf_pkg::EXP_W-1:0]    exponent;
    logic                         last;
    logic                         no_factors;

    tdf_pkg::result_t factor_q [$];
    int      fail_cnt = 0;
    int      beat_no = 0;
    int      burst_left = 0;

    int small_primes [N_SMALL] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
                                   31, 37, 41, 43, 47, 53, 59, 61};

    dir_row_t dir_tab [N_DIR] = '{
        '{32'd0,          1'b1, 32'd0,     6'd0,  1'b1},
        '{32'd1,          1'b1, 32'd0,     6'd0,  1'b1},
        '{32'd2,          1'b1, 32'd2,     6'd1,  1'b0},
        '{32'd3,          1'b1, 32'd3,     6'd1,  1'b0},
        '{32'd4,          1'b1, 32'd2,     6'd2,  1'b0},
        '{32'd25,         1'b1, 32'd5,     6'd2,  1'b0},
        '{32'd4096,       1'b1, 32'd2,     6'd12, 1'b0},
        '{32'd65521,      1'b1, 32'd65521, 6'd1,  1'b0},
        '{32'h8000_0000,  1'b1, 32'd2,     6'd31, 1'b0},
        '{32'd994009,     1'b1, 32'd997,   6'd2,  1'b0},
        '{32'd3486784401, 1'b1, 32'd3,     6'd20, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 32'd0,     6'd0,  1'b0},
        '{32'd223092870,  1'b0, 32'd0,     6'd0,  1'b0},
        '{32'd6,          1'b0, 32'd0,     6'd0,  1'b0},
        '{32'd12,         1'b0, 32'd0,     6'd0,  1'b0},
        '{32'hFFF1_0000,  1'b0, 32'd0,     6'd0,  1'b0},
        '{32'hC000_0000,  1'b0, 32'd0,     6'd0,  1'b0},
        '{32'd3027,       1'b0, 32'd0,     6'd0,  1'b0},
        '{32'd151200,     1'b0, 32'd0,     6'd0,  1'b0},
        '{32'h5555_5555,  1'b0, 32'd0,     6'd0,  1'b0},
        '{32'hAAAA_AAAA,  1'b0, 32'd0,     6'd0,  1'b0}
    };

    trial_division_factorizer_unit #(
        .VALUE_BITS(VB)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prime_factor (prime_factor),
        .exponent     (exponent),
        .last         (last),
        .no_factors   (no_factors)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append one expected beat
    function automatic void queue_beat(input tdf_pkg::result_t r);
        factor_q = {factor_q, r};
    endfunction

    // Expected prime/exponent beats for one value, in ascending order
    function automatic void predict_factors(input logic [31:0] v);
        logic [63:0]      rem;
        logic [63:0]      d;
        tdf_pkg::exp_t    mult;
        int               cnt;
        tdf_pkg::result_t held;
        logic             have_held;
        rem = {32'd0, v} & VALUE_MASK;
        d = 64'd2;
        cnt = 0;
        have_held = 1'b0;
        held = '0;
        if (rem <= 64'd1)
        begin
            held.no_factors = 1'b1;
            held.last = 1'b1;
            queue_beat(held);
            return;
        end
        while (d <= rem / d)
        begin
            if (rem % d == 64'd0)
            begin
                mult = '0;
                while (rem % d == 64'd0)
                begin
                    rem = rem / d;
                    mult = mult + 1'b1;
                end
                if (have_held)
                    queue_beat(held);
                held = '{prime_factor: d[31:0], exponent: mult, last: 1'b0, no_factors: 1'b0};
                have_held = 1'b1;
                cnt++;
                // result cap reached: this beat closes the value
                if (cnt >= tdf_pkg::MAX_RESULTS)
                begin
                    held.last = 1'b1;
                    queue_beat(held);
                    return;
                end
            end
            d = d + 64'd1;
        end
        // leftover prime above the square-root bound
        if (rem > 64'd1)
        begin
            if (have_held)
                queue_beat(held);
            held = '{prime_factor: rem[31:0], exponent: tdf_pkg::EXP_ONE, last: 1'b0,
                     no_factors: 1'b0};
        end
        held.last = 1'b1;
        queue_beat(held);
    endfunction

    // Product of random small prime powers, sometimes times a cofactor below 4096,
    // so the divisor walk stays short
    function automatic logic [31:0] smooth_value();
        logic [63:0] prod;
        logic [63:0] p;
        logic [63:0] cof;
        int          n;
        int          e;
        prod = 64'd1;
        n = $urandom_range(1, 9);
        for (int k = 0; k < n; k++)
        begin
            p = 64'(small_primes[$urandom_range(0, N_SMALL - 1)]);
            e = $urandom_range(1, 8);
            for (int j = 0; j < e; j++)
                if (prod * p <= U32_MAX)
                    prod = prod * p;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            cof = 64'($urandom_range(2, 4095));
            if (prod * cof <= U32_MAX)
                prod = prod * cof;
        end
        return prod[31:0];
    endfunction

    // Highest power of one small prime that fits in 32 bits
    function automatic logic [31:0] top_power();
        logic [63:0] prod;
        logic [63:0] p;
        prod = 64'd1;
        p = 64'(small_primes[$urandom_range(0, N_SMALL - 1)]);
        while (prod * p <= U32_MAX)
            prod = prod * p;
        return prod[31:0];
    endfunction

    // Offer one value; bursts of back-to-back beats with random gaps between them
    task automatic send_value(input logic [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                value <= $urandom;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Receiver stall pattern: free-running, random, short periodic, long stalls
    int stall_mode = 0;
    int mode_left = 0;
    int phase = 0;
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ((phase % 5) < 2);
            default: out_ready <= ((phase % 32) >= 24);
        endcase
    end

    // Result beat check against the oldest expectation
    always @(posedge clk)
    begin
        tdf_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beat_no++;
            if (factor_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("beat %0d: unexpected p=%0d e=%0d last=%b nf=%b",
                             beat_no, prime_factor, exponent, last, no_factors);
            end
            else
            begin
                want = factor_q.pop_front();
                if (prime_factor !== want.prime_factor || exponent !== want.exponent ||
                    last !== want.last || no_factors !== want.no_factors)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("beat %0d: expected p=%0d e=%0d last=%b nf=%b,",
                                 beat_no, want.prime_factor, want.exponent, want.last,
                                 want.no_factors, " got p=%0d e=%0d last=%b nf=%b",
                                 prime_factor, exponent, last, no_factors);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        tdf_pkg::result_t typed_res;
        logic [31:0]      v;
        int               pick;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            send_value(dir_tab[i].v);
            if (dir_tab[i].typed)
            begin
                typed_res = '{prime_factor: dir_tab[i].p, exponent: dir_tab[i].e,
                              last: 1'b1, no_factors: dir_tab[i].nf};
                queue_beat(typed_res);
            end
            else
                predict_factors(dir_tab[i].v);
        end

        // random values, mostly smooth so every beat kind comes out often
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                v = smooth_value();
            else if (pick < 88)
                v = $urandom_range(0, 65535);
            else if (pick < 94)
                v = $urandom_range(0, 1);
            else
                v = top_power();
            send_value(v);
            predict_factors(v);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then watch for stray beats
        while (factor_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (fail_cnt == 0 && factor_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
